[sv/assert_macros.svh]
// Assertion macros for the RTL file that checks its own logic.
// No dependencies; the guard keeps repeated inclusion harmless.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, idle during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, idle during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

[sv/dibrgba_pkg.sv]
// Shared types, codes and helper functions for the DIB pixel to RGBA unit.
// No dependencies; the RTL files refer to it by scoped names, the simulation files import it.
package dibrgba_pkg;

   // Geometry and palette sizes
   localparam int DIM_W     = 8;
   localparam int CFG_DIM_W = 9;
   localparam int BPP_W     = 6;
   localparam int PAL_DEPTH = 256;
   localparam int PAL_AW    = $clog2(PAL_DEPTH);
   localparam int COLOR_W   = 24;
   localparam int PIX_W     = 32;
   localparam int CHAN_W    = 8;
   localparam int CSR_IDX_W = 2;

   // Request kinds
   localparam logic REQ_PALETTE = 1'b0;
   localparam logic REQ_PIXEL   = 1'b1;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BPP          = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK_ENABLE  = 2'd3;

   // Source depths
   localparam logic [BPP_W-1:0] BPP_1  = 6'd1;
   localparam logic [BPP_W-1:0] BPP_4  = 6'd4;
   localparam logic [BPP_W-1:0] BPP_8  = 6'd8;
   localparam logic [BPP_W-1:0] BPP_24 = 6'd24;
   localparam logic [BPP_W-1:0] BPP_32 = 6'd32;

   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;
   localparam logic [3:0]        NIBBLE_MASK  = 4'hF;

   // How a pixel's color is formed
   typedef enum logic [1:0] {
      MODE_BGRA  = 2'd0,
      MODE_BGR   = 2'd1,
      MODE_INDEX = 2'd2,
      MODE_BLACK = 2'd3
   } mode_type;

   typedef struct packed {
      logic                req_type;
      logic [PAL_AW-1:0]   palette_index;
      logic [COLOR_W-1:0]  palette_color;
      logic [PIX_W-1:0]    pixel_bytes;
      logic [CHAN_W-1:0]   mask_byte;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0]   red;
      logic [CHAN_W-1:0]   green;
      logic [CHAN_W-1:0]   blue;
      logic [CHAN_W-1:0]   alpha;
      logic [DIM_W-1:0]    out_col;
      logic [DIM_W-1:0]    out_row;
      logic                last_pixel;
   } rsp_type;

   typedef struct packed {
      logic [CFG_DIM_W-1:0] image_width;
      logic [CFG_DIM_W-1:0] image_height;
      logic [BPP_W-1:0]     bits_per_pixel;
      logic                 mask_enable;
   } cfg_type;

   // Pipeline handshake controls from the top level
   typedef struct packed {
      logic pix_accept;
      logic pal_write;
      logic s1_move;
   } ctl_type;

   // Decoded pixel held between the scan stage and the output register
   typedef struct packed {
      mode_type            mode;
      logic [PIX_W-1:0]    pixel_bytes;
      logic                masked;
      logic [DIM_W-1:0]    out_col;
      logic [DIM_W-1:0]    out_row;
      logic                last_pixel;
   } stage_type;

   // Last valid coordinate for a configured dimension: zero acts as one,
   // anything past the top saturates.
   function automatic logic [DIM_W-1:0] dim_last(input logic [CFG_DIM_W-1:0] v);
      logic [DIM_W-1:0] res;
      if (v == '0) begin
         res = '0;
      end else if (v[CFG_DIM_W-1]) begin
         res = '1;
      end else begin
         res = v[DIM_W-1:0] - DIM_W'(1);
      end
      return res;
   endfunction

endpackage

[sv/dibrgba_palette.sv]
// Palette memory: one write port, one registered read port.
// Depends on dibrgba_pkg for sizes.
module dibrgba_palette (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [dibrgba_pkg::PAL_AW-1:0]      wr_addr,
   input  logic [dibrgba_pkg::COLOR_W-1:0]     wr_data,
   input  logic                                rd_en,
   input  logic [dibrgba_pkg::PAL_AW-1:0]      rd_addr,
   output logic [dibrgba_pkg::COLOR_W-1:0]     rd_data
);

   logic [dibrgba_pkg::COLOR_W-1:0] mem [dibrgba_pkg::PAL_DEPTH];
   logic [dibrgba_pkg::COLOR_W-1:0] rd_data_ff;

   // Write an entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read and hold until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/dibrgba_scan.sv]
// Scan stage: column/row counters, depth decode, palette index selection
// and the first pipeline register. Depends on dibrgba_pkg.
module dibrgba_scan (
   input  logic                             clock,
   input  logic                             reset,
   input  dibrgba_pkg::cfg_type             cfg,
   input  dibrgba_pkg::req_type             req,
   input  dibrgba_pkg::ctl_type             ctl,
   output logic [dibrgba_pkg::PAL_AW-1:0]   pal_rd_addr,
   output dibrgba_pkg::stage_type           s1,
   output logic                             s1_valid
);

   logic [dibrgba_pkg::DIM_W-1:0] col_ff, col_in;
   logic [dibrgba_pkg::DIM_W-1:0] row_ff, row_in;
   logic [dibrgba_pkg::DIM_W-1:0] w_last, h_last;
   logic                          last_col, last_row;
   logic [2:0]                    bit_sel;
   logic [dibrgba_pkg::CHAN_W-1:0] lo;
   dibrgba_pkg::mode_type         mode;
   dibrgba_pkg::stage_type        s1_ff, s1_in;
   logic                          s1_valid_ff, s1_valid_in;

   assign w_last   = dibrgba_pkg::dim_last(cfg.image_width);
   assign h_last   = dibrgba_pkg::dim_last(cfg.image_height);
   assign last_col = (col_ff >= w_last);
   assign last_row = (row_ff >= h_last);
   assign bit_sel  = 3'd7 - col_ff[2:0];
   assign lo       = req.pixel_bytes[dibrgba_pkg::CHAN_W-1:0];

   // Decode depth and pick the palette index
   always_comb begin
      mode        = dibrgba_pkg::MODE_BLACK;
      pal_rd_addr = lo;
      case (cfg.bits_per_pixel) inside
         dibrgba_pkg::BPP_32: mode = dibrgba_pkg::MODE_BGRA;
         dibrgba_pkg::BPP_24: mode = dibrgba_pkg::MODE_BGR;
         dibrgba_pkg::BPP_8: begin
            mode        = dibrgba_pkg::MODE_INDEX;
            pal_rd_addr = lo;
         end
         dibrgba_pkg::BPP_4: begin
            mode        = dibrgba_pkg::MODE_INDEX;
            pal_rd_addr = col_ff[0] ? {4'd0, lo[3:0] & dibrgba_pkg::NIBBLE_MASK}
                                    : {4'd0, lo[7:4]};
         end
         dibrgba_pkg::BPP_1: begin
            mode        = dibrgba_pkg::MODE_INDEX;
            pal_rd_addr = {7'd0, lo[bit_sel]};
         end
         default: mode = dibrgba_pkg::MODE_BLACK;
      endcase
   end

   // Advance counters in stored scan order
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (ctl.pix_accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + dibrgba_pkg::DIM_W'(1);
         end else begin
            col_in = col_ff + dibrgba_pkg::DIM_W'(1);
         end
      end
   end

   // Build the stage word
   always_comb begin
      s1_in             = s1_ff;
      s1_in.mode        = mode;
      s1_in.pixel_bytes = req.pixel_bytes;
      s1_in.masked      = cfg.mask_enable & req.mask_byte[bit_sel];
      s1_in.out_col     = col_ff;
      s1_in.out_row     = h_last - row_ff;
      s1_in.last_pixel  = last_col & last_row;
   end

   // Fill on a pixel, drain when the output register takes it
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (ctl.pix_accept) begin
         s1_valid_in = 1'b1;
      end else if (ctl.s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.pix_accept) begin
         s1_ff <= s1_in;
      end
   end

   assign s1       = s1_ff;
   assign s1_valid = s1_valid_ff;

endmodule

[sv/dibrgba_format.sv]
// Output stage: forms R, G, B, A from the decoded word and palette color,
// applies the mask and holds the result word. Depends on dibrgba_pkg.
module dibrgba_format (
   input  logic                               clock,
   input  logic                               reset,
   input  dibrgba_pkg::stage_type             s1,
   input  logic                               s1_valid,
   input  logic [dibrgba_pkg::COLOR_W-1:0]    pal_color,
   output logic                               out_ready,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output dibrgba_pkg::rsp_type               rsp_payload
);

   dibrgba_pkg::rsp_type rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   assign out_ready = !rsp_valid_ff || !rsp_stall;

   // Unpack color by mode
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_in.alpha = dibrgba_pkg::ALPHA_OPAQUE;
      case (s1.mode)
         dibrgba_pkg::MODE_BGRA: begin
            rsp_in.blue  = s1.pixel_bytes[7:0];
            rsp_in.green = s1.pixel_bytes[15:8];
            rsp_in.red   = s1.pixel_bytes[23:16];
            rsp_in.alpha = s1.pixel_bytes[31:24];
         end
         dibrgba_pkg::MODE_BGR: begin
            rsp_in.blue  = s1.pixel_bytes[7:0];
            rsp_in.green = s1.pixel_bytes[15:8];
            rsp_in.red   = s1.pixel_bytes[23:16];
         end
         dibrgba_pkg::MODE_INDEX: begin
            rsp_in.blue  = pal_color[7:0];
            rsp_in.green = pal_color[15:8];
            rsp_in.red   = pal_color[23:16];
         end
         default: begin
            rsp_in.blue  = '0;
            rsp_in.green = '0;
            rsp_in.red   = '0;
         end
      endcase
      // Drop alpha for a masked pixel
      if (s1.masked) begin
         rsp_in.alpha = '0;
      end
      rsp_in.out_col    = s1.out_col;
      rsp_in.out_row    = s1.out_row;
      rsp_in.last_pixel = s1.last_pixel;
   end

   // Load when free, clear when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_ready) begin
         rsp_valid_in = s1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && s1_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[sv/dib_pixel_to_rgba_unit.sv]
// DIB pixel to RGBA converter for icon images.
// Input channel (req_*): one word per cycle while req_stall is low, valid/stall. A palette word
// writes one 24-bit color entry and gives no result. A pixel word carries
// the raw source bytes and the AND-mask byte, and gives one RGBA result
// with top-down coordinates; last_pixel marks the end of the image.
// Result channel (rsp_*): valid/stall, fed from an output register.
// Config channel (csr_*): valid/ready, always ready; write only while idle.
// A pixel passes through the scan stage register, then the output register, to rsp_valid.
// Throughput: one word per cycle while req_stall is low; the palette memory's
// registered read port sets the two-stage depth. A palette write taken ahead of
// a pixel is seen by that pixel.
// When the receiver stalls, the result word holds, one more pixel waits in
// the scan stage and req_stall rises once both are full.
// Reset clears counters, pipeline valids and the configuration registers
// (width 32, height 32, 32 bits per pixel, mask enabled); palette contents
// are undefined until written.
// Depends on dibrgba_pkg, dibrgba_scan, dibrgba_palette, dibrgba_format and assert_macros.svh.
`include "assert_macros.svh"

module dib_pixel_to_rgba_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  dibrgba_pkg::req_type                  req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output dibrgba_pkg::rsp_type                  rsp_payload,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [dibrgba_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dibrgba_pkg::CFG_DIM_W-1:0]     csr_data
);

   dibrgba_pkg::cfg_type             cfg_ff, cfg_in;
   dibrgba_pkg::ctl_type             ctl;
   dibrgba_pkg::stage_type           s1;
   logic                             s1_valid;
   logic                             out_ready;
   logic                             can_accept;
   logic                             req_accept;
   logic [dibrgba_pkg::PAL_AW-1:0]   pal_rd_addr;
   logic [dibrgba_pkg::COLOR_W-1:0]  pal_color;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            dibrgba_pkg::CSR_IMAGE_WIDTH:  cfg_in.image_width  = csr_data;
            dibrgba_pkg::CSR_IMAGE_HEIGHT: cfg_in.image_height = csr_data;
            dibrgba_pkg::CSR_BPP:
               cfg_in.bits_per_pixel = csr_data[dibrgba_pkg::BPP_W-1:0];
            dibrgba_pkg::CSR_MASK_ENABLE:  cfg_in.mask_enable  = csr_data[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width    <= dibrgba_pkg::CFG_DIM_W'(32);
         cfg_ff.image_height   <= dibrgba_pkg::CFG_DIM_W'(32);
         cfg_ff.bits_per_pixel <= dibrgba_pkg::BPP_32;
         cfg_ff.mask_enable    <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Handshake: take a word while the scan stage is empty or draining
   assign can_accept     = !s1_valid || out_ready;
   assign req_stall      = !can_accept;
   assign req_accept     = req_valid && can_accept;
   assign ctl.pix_accept = req_accept && (req_payload.req_type == dibrgba_pkg::REQ_PIXEL);
   assign ctl.pal_write  = req_accept && (req_payload.req_type == dibrgba_pkg::REQ_PALETTE);
   assign ctl.s1_move    = s1_valid && out_ready;

   dibrgba_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req         (req_payload),
      .ctl         (ctl),
      .pal_rd_addr (pal_rd_addr),
      .s1          (s1),
      .s1_valid    (s1_valid)
   );

   dibrgba_palette u_palette (
      .clock   (clock),
      .wr_en   (ctl.pal_write),
      .wr_addr (req_payload.palette_index),
      .wr_data (req_payload.palette_color),
      .rd_en   (ctl.pix_accept),
      .rd_addr (pal_rd_addr),
      .rd_data (pal_color)
   );

   dibrgba_format u_format (
      .clock       (clock),
      .reset       (reset),
      .s1          (s1),
      .s1_valid    (s1_valid),
      .pal_color   (pal_color),
      .out_ready   (out_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // Checks
   `ASSERT_IMPLIES(a_stall_only_when_full, clock, reset, req_stall, s1_valid && rsp_valid)
   `ASSERT_NEXT(a_pixel_enters_stage, clock, reset, ctl.pix_accept, s1_valid)
   `ASSERT_NEXT(a_palette_gives_no_rsp, clock, reset, ctl.pal_write && !s1_valid, !s1_valid)

endmodule

[sim/dib_pixel_to_rgba_checker.sv]
// Checker for the DIB pixel to RGBA unit: watches the three channels, predicts each
// RGBA word and compares it field by field. Depends on dibrgba_pkg only.
module dib_pixel_to_rgba_checker
   import dibrgba_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_type               req_payload,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_type               rsp_payload,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CFG_DIM_W-1:0]  csr_data,
   output int                    mismatch_count,
   output int                    pixels_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   // Shadow configuration and scan state
   logic [CFG_DIM_W-1:0] width_cfg;
   logic [CFG_DIM_W-1:0] height_cfg;
   logic [BPP_W-1:0]     depth_cfg;
   logic                 mask_cfg;
   logic [DIM_W-1:0]     scan_col;
   logic [DIM_W-1:0]     scan_row;
   logic [COLOR_W-1:0]   palette_copy [PAL_DEPTH];

   rsp_type expected_pixels [$];
   rsp_type oldest;

   initial begin
      mismatch_count = 0;
      pixels_outstanding = 0;
   end

   task automatic report_mismatch(input string what, input int unsigned want,
                                  input int unsigned got);
      $display("%0t ns: %s mismatch, expected 0x%0h got 0x%0h", $time, what, want, got);
      mismatch_count++;
   endtask

   task automatic check_field(input string what, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         report_mismatch(what, want, got);
      end
   endtask

   // Zero behaves as one, anything past 256 saturates
   function automatic int span_of(input logic [CFG_DIM_W-1:0] v);
      if (v == '0) begin
         return 1;
      end
      if (v > 9'd256) begin
         return 256;
      end
      return int'(v);
   endfunction

   // Work out the RGBA word for one pixel and advance the scan position
   function automatic rsp_type convert_pixel(input req_type word);
      rsp_type res;
      int w, h, x, y, bitpos;
      logic [7:0] low, slot;
      logic [COLOR_W-1:0] color;
      logic indexed, end_of_row, end_of_image;
      w = span_of(width_cfg);
      h = span_of(height_cfg);
      x = int'(scan_col);
      y = int'(scan_row);
      bitpos = 7 - (x % 8);
      low = word.pixel_bytes[7:0];
      res = '0;
      res.alpha = ALPHA_OPAQUE;
      indexed = 1'b1;
      slot = '0;
      case (depth_cfg)
         BPP_32: begin
            {res.alpha, res.red, res.green, res.blue} = word.pixel_bytes;
            indexed = 1'b0;
         end
         BPP_24: begin
            {res.red, res.green, res.blue} = word.pixel_bytes[23:0];
            indexed = 1'b0;
         end
         BPP_8: slot = low;
         BPP_4: slot = (x % 2 == 0) ? {4'h0, low[7:4]} : {4'h0, low[3:0]};
         BPP_1: slot = {7'd0, low[bitpos]};
         default: indexed = 1'b0;
      endcase
      if (indexed) begin
         color = palette_copy[slot];
         {res.red, res.green, res.blue} = color;
      end
      // With masking on, a set mask bit makes the pixel transparent
      if (mask_cfg && word.mask_byte[bitpos]) begin
         res.alpha = '0;
      end
      end_of_row = (x >= w - 1);
      end_of_image = (y >= h - 1);
      res.out_col = 8'(x);
      res.out_row = 8'(h - 1 - y);
      res.last_pixel = end_of_row && end_of_image;
      if (end_of_row) begin
         scan_col = '0;
         scan_row = end_of_image ? '0 : 8'(y + 1);
      end else begin
         scan_col = 8'(x + 1);
      end
      return res;
   endfunction

   // Follow the channels in handshake order: registers, requests, results
   always @(posedge clock) begin
      if (reset) begin
         width_cfg = 9'd32;
         height_cfg = 9'd32;
         depth_cfg = BPP_32;
         mask_cfg = 1'b1;
         scan_col = '0;
         scan_row = '0;
         expected_pixels.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  width_cfg = csr_data;
               CSR_IMAGE_HEIGHT: height_cfg = csr_data;
               CSR_BPP:          depth_cfg = csr_data[BPP_W-1:0];
               CSR_MASK_ENABLE:  mask_cfg = csr_data[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (req_payload.req_type == REQ_PIXEL) begin
               expected_pixels.push_back(convert_pixel(req_payload));
            end else begin
               palette_copy[req_payload.palette_index] = req_payload.palette_color;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch("unexpected word", 0, 32'(rsp_payload));
            end else begin
               oldest = expected_pixels.pop_front();
               check_field("red", oldest.red, rsp_payload.red);
               check_field("green", oldest.green, rsp_payload.green);
               check_field("blue", oldest.blue, rsp_payload.blue);
               check_field("alpha", oldest.alpha, rsp_payload.alpha);
               check_field("out_col", oldest.out_col, rsp_payload.out_col);
               check_field("out_row", oldest.out_row, rsp_payload.out_row);
               check_field("last_pixel", {7'd0, oldest.last_pixel},
                           {7'd0, rsp_payload.last_pixel});
            end
         end
      end
      pixels_outstanding <= expected_pixels.size();
   end

endmodule

[sim/tb_dib_pixel_to_rgba_unit.sv]
// Testbench top for the DIB pixel to RGBA unit: clock, reset, stimulus and verdict.
// Depends on dibrgba_pkg, dib_pixel_to_rgba_unit and dib_pixel_to_rgba_checker.
module tb_dib_pixel_to_rgba_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import dibrgba_pkg::*;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_payload;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_DIM_W-1:0] csr_data = '0;
   int                   mismatches;
   int                   pixels_outstanding;

   int          burst_left = 0;
   int          stall_mode = 0;
   int          stall_hold = 0;
   logic [31:0] stall_tick = '0;

   dib_pixel_to_rgba_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   dib_pixel_to_rgba_checker u_rgba_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_payload        (req_payload),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_payload        (rsp_payload),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .mismatch_count     (mismatches),
      .pixels_outstanding (pixels_outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: switch between free flow, light, heavy and periodic stalls
   always @(negedge clock) begin
      stall_tick <= stall_tick + 1;
      if (stall_hold == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_hold <= $urandom_range(20, 200);
      end else begin
         stall_hold <= stall_hold - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= stall_tick[4];
      endcase
   end

   // Present one word in a burst, open a new burst after a random gap, hold until taken
   task automatic send_word(input req_type word);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid <= 1'b1;
      req_payload <= word;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      burst_left--;
      @(negedge clock);
   endtask

   task automatic put_pixel(input logic [31:0] bytes, input logic [7:0] mbyte);
      req_type word;
      word.req_type = REQ_PIXEL;
      word.palette_index = 8'($urandom);
      word.palette_color = 24'($urandom);
      word.pixel_bytes = bytes;
      word.mask_byte = mbyte;
      send_word(word);
   endtask

   task automatic put_palette(input logic [7:0] slot, input logic [23:0] color);
      req_type word;
      word.req_type = REQ_PALETTE;
      word.palette_index = slot;
      word.palette_color = color;
      word.pixel_bytes = $urandom;
      word.mask_byte = 8'($urandom);
      send_word(word);
   endtask

   // Drop valid, drain every result, then let the pipeline settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pixels_outstanding != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CFG_DIM_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   task automatic set_config(input logic [CFG_DIM_W-1:0] w, input logic [CFG_DIM_W-1:0] h,
                             input logic [BPP_W-1:0] depth, input logic mask_on);
      wait_idle();
      write_csr(CSR_IMAGE_WIDTH, w);
      write_csr(CSR_IMAGE_HEIGHT, h);
      write_csr(CSR_BPP, {3'b000, depth});
      write_csr(CSR_MASK_ENABLE, {8'd0, mask_on});
      csr_valid <= 1'b0;
   endtask

   // Mostly tiny images so last_pixel comes often, with zero and saturated sizes mixed in
   function automatic logic [CFG_DIM_W-1:0] pick_dim();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return '0;
      if (r == 1) return 9'd256;
      if (r == 2) return 9'($urandom_range(257, 511));
      if (r < 6) return 9'($urandom_range(1, 64));
      return 9'($urandom_range(1, 8));
   endfunction

   function automatic logic [BPP_W-1:0] pick_depth();
      case ($urandom_range(0, 9))
         0: return 6'($urandom_range(0, 63));
         1, 2: return BPP_1;
         3, 4: return BPP_4;
         5, 6: return BPP_8;
         7: return BPP_24;
         default: return BPP_32;
      endcase
   endfunction

   initial begin
      #3_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int span;
      int random_items;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Fill the whole palette so no pixel ever reads an unwritten entry
      for (int i = 0; i < PAL_DEPTH; i++) begin
         put_palette(8'(i), (i == 0) ? 24'h000000 : (i == 1) ? 24'hFFFFFF : 24'($urandom));
      end

      // 32-bit pixels through one whole 2x2 image, mask on
      set_config(9'd2, 9'd2, BPP_32, 1'b1);
      put_pixel(32'hFFFF_FFFF, 8'h00);
      put_pixel(32'h0000_0000, 8'hFF);
      put_pixel(32'hA5C3_0F81, 8'h80);
      put_pixel(32'h5A3C_F07E, 8'h7F);
      // 24-bit pixels, mask off keeps alpha opaque
      set_config(9'd2, 9'd1, BPP_24, 1'b0);
      put_pixel(32'hFFFF_FFFF, 8'hFF);
      put_pixel(32'h0000_0000, 8'h00);
      // 8-bit index extremes, each right after its entry is written
      set_config(9'd3, 9'd1, BPP_8, 1'b1);
      put_palette(8'hFF, 24'hFFFFFF);
      put_pixel(32'h0000_00FF, 8'h00);
      put_palette(8'h00, 24'h000000);
      put_pixel(32'hFFFF_FF00, 8'hFF);
      // 4-bit: high nibble on even columns, low nibble on odd ones
      set_config(9'd2, 9'd1, BPP_4, 1'b1);
      put_pixel(32'h0000_00F0, 8'h40);
      put_pixel(32'h0000_000F, 8'h40);
      // 1-bit: bit picked by column
      set_config(9'd8, 9'd1, BPP_1, 1'b1);
      put_pixel(32'h0000_0080, 8'h00);
      put_pixel(32'h0000_00BF, 8'h40);
      // zero size counts as one; unknown depth gives black
      set_config(9'd0, 9'd0, 6'd0, 1'b1);
      put_pixel(32'hFFFF_FFFF, 8'h80);
      // oversize dimensions saturate, largest unknown depth
      set_config(9'd511, 9'd300, 6'd63, 1'b0);
      put_pixel(32'hFFFF_FFFF, 8'hFF);
      put_pixel(32'h1234_5678, 8'h00);
      // shrink the image mid-row so the counters sit past the new edge
      set_config(9'd16, 9'd16, BPP_24, 1'b1);
      repeat (6) put_pixel($urandom, 8'($urandom));
      set_config(9'd3, 9'd2, BPP_32, 1'b0);
      repeat (2) put_pixel($urandom, 8'($urandom));

      // Random phases: new settings, then a stream of mostly pixels
      random_items = 0;
      while (random_items < 560) begin
         set_config(pick_dim(), pick_dim(), pick_depth(), 1'($urandom));
         span = $urandom_range(15, 60);
         repeat (span) begin
            if ($urandom_range(0, 6) == 0) begin
               put_palette(8'($urandom), 24'($urandom));
            end else begin
               put_pixel($urandom, 8'($urandom));
            end
            random_items++;
         end
      end

      wait_idle();
      repeat (6) @(negedge clock);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+sv
sv/dibrgba_pkg.sv
sv/dibrgba_palette.sv
sv/dibrgba_scan.sv
sv/dibrgba_format.sv
sv/dib_pixel_to_rgba_unit.sv
sim/dib_pixel_to_rgba_checker.sv
sim/tb_dib_pixel_to_rgba_unit.sv
